[hdl/crv_pkg.sv]
// Package for the command report validator: verdict codes, command codes,
// header layout constants and the verdict record. No dependencies.
`default_nettype none

package crv_pkg;

    // Verdict codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE      = 3'd1;
    localparam logic [2:0] ST_BAD_SIGNATURE = 3'd2;
    localparam logic [2:0] ST_BAD_CHECKSUM  = 3'd3;
    localparam logic [2:0] ST_BAD_COMMAND   = 3'd4;

    // Command codes
    localparam logic [7:0] CODE_ERASE = 8'h71;
    localparam logic [7:0] CODE_READ  = 8'hD2;
    localparam logic [7:0] CODE_WRITE = 8'hC3;

    // Header layout, byte offsets
    localparam int OFS_SIZE  = 1;
    localparam int OFS_START = 2;
    localparam int OFS_COUNT = 6;
    localparam int OFS_SIG   = 10;
    localparam int OFS_SUM   = 14;
    localparam int HDR_LEN   = 18;

    localparam logic [7:0]  HEADER_BYTES    = 8'd18;
    localparam logic [31:0] SIGNATURE_RESET = 32'h4344_4948;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command;
        logic [31:0] start_arg;
        logic [31:0] count_arg;
    } t_verdict;

endpackage

`default_nettype wire

[hdl/crv_byte_if.sv]
// Byte stream channel for the command report validator.
// Depends on nothing; carries one report byte and its end marker.
`default_nettype none

interface crv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

[hdl/crv_verdict_if.sv]
// Verdict channel for the command report validator.
// Depends on nothing; carries status and the decoded command header.
`default_nettype none

interface crv_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [31:0] start_arg;
    logic [31:0] count_arg;

    modport source (output valid, output status, output command,
                    output start_arg, output count_arg, input ready);
    modport sink   (input valid, input status, input command,
                    input start_arg, input count_arg, output ready);
endinterface

`default_nettype wire

[hdl/crv_frame.sv]
// Frame state of the validator: header capture, running sum and verdict logic.
// Depends on crv_pkg.
`default_nettype none

module crv_frame #(
    parameter int MAX_REPORT_BYTES = 512
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last,
    input  wire logic [31:0]       i_expected_signature,
    output crv_pkg::t_verdict      o_verdict
);

    localparam int IDX_W = $clog2(MAX_REPORT_BYTES + 1);
    localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;

    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [7:0]       r_size,  n_size;
    logic [7:0]       r_cmd,   n_cmd;
    logic [31:0]      r_start, n_start;
    logic [31:0]      r_count, n_count;
    logic [31:0]      r_sig,   n_sig;
    logic [31:0]      r_csum,  n_csum;
    logic [31:0]      r_sum,   n_sum;
    logic [1:0]       lane;
    logic             size_bad;
    logic             cmd_known;

    assign lane = r_idx[1:0] - 2'd2;

    // Next frame state for the byte at the current position
    always_comb begin
        n_idx   = r_idx;
        n_size  = r_size;
        n_cmd   = r_cmd;
        n_start = r_start;
        n_count = r_count;
        n_sig   = r_sig;
        n_csum  = r_csum;
        n_sum   = r_sum;
        if (r_idx == '0) begin
            n_cmd = i_data_byte;
        end else if (r_idx == IDX_W'(crv_pkg::OFS_SIZE)) begin
            n_size = i_data_byte;
            n_sum  = ((i_data_byte >= 8'd1) ? {24'd0, r_cmd} : 32'd0)
                   + ((i_data_byte >= 8'd2) ? {24'd0, i_data_byte} : 32'd0);
        end else begin
            if (r_idx < IDX_W'(crv_pkg::OFS_COUNT)) begin
                n_start[lane*8 +: 8] = i_data_byte;
            end else if (r_idx < IDX_W'(crv_pkg::OFS_SIG)) begin
                n_count[lane*8 +: 8] = i_data_byte;
            end else if (r_idx < IDX_W'(crv_pkg::OFS_SUM)) begin
                n_sig[lane*8 +: 8] = i_data_byte;
            end else if (r_idx < IDX_W'(crv_pkg::HDR_LEN)) begin
                n_csum[lane*8 +: 8] = i_data_byte;
            end
            if (CMP_W'(r_idx) < CMP_W'(r_size)) begin
                n_sum = r_sum + {24'd0, i_data_byte};
            end
        end
        // Saturate the byte count at the report limit
        if (r_idx < IDX_W'(MAX_REPORT_BYTES)) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // Verdict from the updated state, first failure wins
    assign size_bad  = (n_size > crv_pkg::HEADER_BYTES) || (CMP_W'(n_size) > CMP_W'(n_idx));
    assign cmd_known = (n_cmd == crv_pkg::CODE_ERASE) || (n_cmd == crv_pkg::CODE_READ)
                    || (n_cmd == crv_pkg::CODE_WRITE);

    always_comb begin
        o_verdict.command   = n_cmd;
        o_verdict.start_arg = n_start;
        o_verdict.count_arg = n_count;
        if (size_bad) begin
            o_verdict.status = crv_pkg::ST_BAD_SIZE;
        end else if (n_sig != i_expected_signature) begin
            o_verdict.status = crv_pkg::ST_BAD_SIGNATURE;
        end else if (n_sum != n_csum) begin
            o_verdict.status = crv_pkg::ST_BAD_CHECKSUM;
        end else if (!cmd_known) begin
            o_verdict.status = crv_pkg::ST_BAD_COMMAND;
        end else begin
            o_verdict.status = crv_pkg::ST_OK;
        end
    end

    // Advance on each byte, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_idx   <= '0;
            r_size  <= '0;
            r_cmd   <= '0;
            r_start <= '0;
            r_count <= '0;
            r_sig   <= '0;
            r_csum  <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_idx   <= n_idx;
            r_size  <= n_size;
            r_cmd   <= n_cmd;
            r_start <= n_start;
            r_count <= n_count;
            r_sig   <= n_sig;
            r_csum  <= n_csum;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

[hdl/command_report_validator.sv]
// Top level of the command report validator: input register, frame logic,
// verdict register and signature register. Depends on crv_pkg, crv_byte_if,
// crv_verdict_if and crv_frame.
//
//  Port         Dir  Payload                                 Request
//  i_byte       in   data_byte[7:0], last                    one report byte
//  o_verdict    out  status[2:0], command[7:0],              one verdict per report
//                    start_arg[31:0], count_arg[31:0]
//  i_cfg_wr_*   in   wr_data[31:0]                           expected signature write
//
// One byte per cycle sustained while the verdict is not stalled; a verdict becomes valid
// once the last byte moves from the input register into the verdict register.
// Reset is synchronous, active low, and clears the frame and sets the signature.
// A stalled verdict holds only the last byte of the next report in the input
// register; other bytes keep flowing.
`default_nettype none

module command_report_validator #(
    parameter int MAX_REPORT_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    crv_byte_if.sink         i_byte,
    crv_verdict_if.source    o_verdict,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    crv_pkg::t_verdict r_out;
    crv_pkg::t_verdict verdict;
    logic [31:0]       r_expected_signature;
    logic              out_free;
    logic              step;

    // Hand off from input register to frame logic
    assign out_free     = !r_out_valid || o_verdict.ready;
    assign step         = r_in_valid && (!r_in_last || out_free);
    assign i_byte.ready = !r_in_valid || step;

    // Hold the signature register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_signature <= crv_pkg::SIGNATURE_RESET;
        end else if (i_cfg_wr_en) begin
            r_expected_signature <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last;
        end
    end

    crv_frame #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_frame (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (step),
        .i_data_byte          (r_in_byte),
        .i_last               (r_in_last),
        .i_expected_signature (r_expected_signature),
        .o_verdict            (verdict)
    );

    // Verdict register: load on a last byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= verdict;
        end
    end

    assign o_verdict.valid     = r_out_valid;
    assign o_verdict.status    = r_out.status;
    assign o_verdict.command   = r_out.command;
    assign o_verdict.start_arg = r_out.start_arg;
    assign o_verdict.count_arg = r_out.count_arg;

endmodule

`default_nettype wire

[hdl/crv_checker.sv]
// Port-level checks for the command report validator, bound to the top level.
// Depends on crv_pkg.
`default_nettype none

module crv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  out_status,
    input wire logic [7:0]  out_command,
    input wire logic [31:0] out_start_arg
);

    // A stalled verdict holds its status, command and start argument
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
            && $stable(out_command) && $stable(out_start_arg))
        else $error("verdict changed while stalled");

    // Status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status <= crv_pkg::ST_BAD_COMMAND)
        else $error("undefined status code");

    // An ok verdict carries a known command
    a_ok_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == crv_pkg::ST_OK |->
            out_command == crv_pkg::CODE_ERASE || out_command == crv_pkg::CODE_READ
            || out_command == crv_pkg::CODE_WRITE)
        else $error("ok verdict with unknown command");

    // No verdict right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("verdict valid after reset");

endmodule

bind command_report_validator crv_checker u_crv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .out_valid     (o_verdict.valid),
    .out_ready     (o_verdict.ready),
    .out_status    (o_verdict.status),
    .out_command   (o_verdict.command),
    .out_start_arg (o_verdict.start_arg)
);

`default_nettype wire
